// ----- design/point_record_table_radius_query_top_assert.svh -----
// Assertion macros for the record table.
`ifndef POINT_RECORD_TABLE_RADIUS_QUERY_TOP_ASSERT_SVH
`define POINT_RECORD_TABLE_RADIUS_QUERY_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define PRTRQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PRTRQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PRTRQ_ASSERT_IMPL(lbl, ante, cons)
`define PRTRQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/prtrq_pkg.sv -----
`timescale 1ns / 1ps
package prtrq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int NAME_BYTES_DEF = 20;
  localparam int NAME_W = 160;

  typedef enum logic [2:0] {
    CMD_ADD       = 3'd0,
    CMD_LIST      = 3'd1,
    CMD_FIND_NAME = 3'd2,
    CMD_FIND_XY   = 3'd3,
    CMD_DELETE    = 3'd4,
    CMD_RADIUS    = 3'd5
  } cmd_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]         command;
    logic [63:0]        key_part0;
    logic [63:0]        key_part1;
    logic [31:0]        key_part2;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic [23:0]        radius;
  } in_t;

  typedef struct packed {
    logic [1:0]         status_code;
    logic [63:0]        entry_name0;
    logic [63:0]        entry_name1;
    logic [31:0]        entry_name2;
    logic signed [15:0] entry_x;
    logic signed [15:0] entry_y;
    logic               last_item;
  } out_t;

endpackage

// ----- design/point_record_table_radius_query_top.sv -----
// Add: S_ADD, then the result beat. Find and delete: S_RD, S_EV, S_NXT per entry scanned.
// List all: S_RD, S_EV, S_EMIT, S_NXT per entry. Delete then closes up later entries via
// S_SHF, S_SHR, S_SHW. Radius query: S_RSQ for the squared radius, then per entry S_RD,
// S_EV, S_MX, S_MY, S_CMP, S_NXT through the one shared 24x24 multiplier and the single
// table read port; S_EMIT per record given. One command at a time; stall is high meanwhile.
// Reset clears the entry count and control; table contents are not cleared.
`timescale 1ns / 1ps
`include "point_record_table_radius_query_top_assert.svh"
module point_record_table_radius_query_top #(
  parameter int TABLE_DEPTH = prtrq_pkg::DEPTH_DEF,
  parameter int NAME_BYTES  = prtrq_pkg::NAME_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  prtrq_pkg::in_t  cmd,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output prtrq_pkg::out_t rsp
);
  import prtrq_pkg::*;

  localparam int NB = NAME_BYTES * 8;
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic [NB-1:0]      name;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_RSQ, S_RD, S_EV, S_MX, S_MY, S_CMP, S_NXT,
    S_EMIT, S_SHF, S_SHR, S_SHW
  } state_t;

  state_t        state, ret;
  logic [CW-1:0] cnt;
  logic [IW-1:0] idx;
  cmd_e          cmd_q;
  logic [NB-1:0] key_q;
  logic signed [15:0] qx, qy;
  logic [23:0]   rad_q;
  logic [31:0]   r2, acc;
  logic [32:0]   sum;
  logic [15:0]   adx, ady;
  logic          pend;
  rec_t          pend_rec;
  out_t          em;
  rec_t          mem [TABLE_DEPTH];
  rec_t          rdata;

  logic [NAME_W-1:0] key_flat;
  logic [23:0]   ma;
  logic [47:0]   prod;
  logic [16:0]   dx, dy;
  logic          lastidx, we;
  logic [IW-1:0] wa;
  rec_t          wd, new_rec;

  function automatic out_t mk(logic [1:0] st, rec_t r, logic lst);
    logic [NAME_W-1:0] nm;
    out_t o;
    nm = NAME_W'(r.name);
    o.status_code = st;
    o.entry_name0 = nm[63:0];
    o.entry_name1 = nm[127:64];
    o.entry_name2 = nm[159:128];
    o.entry_x = r.x;
    o.entry_y = r.y;
    o.last_item = lst;
    return o;
  endfunction

  assign cmd_stall = (state != S_IDLE);
  assign key_flat = {cmd.key_part2, cmd.key_part1, cmd.key_part0};
  assign new_rec = '{name: key_q, x: qx, y: qy};
  assign lastidx = (CW'(idx) + CW'(1) == cnt);

  always_comb begin
    unique case (state)
      S_RSQ:   ma = rad_q;
      S_MX:    ma = {8'd0, adx};
      default: ma = {8'd0, ady};
    endcase
  end
  assign prod = ma * ma;

  assign dx = {rdata.x[15], rdata.x} - {qx[15], qx};
  assign dy = {rdata.y[15], rdata.y} - {qy[15], qy};

  assign we = (state == S_ADD && cnt != CW'(TABLE_DEPTH)) || state == S_SHW;
  assign wa = (state == S_ADD) ? cnt[IW-1:0] : idx - IW'(1);
  assign wd = (state == S_ADD) ? new_rec : rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      cnt <= '0;
      pend <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (state != S_EMIT && rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_q <= cmd_e'(cmd.command);
            key_q <= key_flat[NB-1:0];
            qx <= cmd.coord_x;
            qy <= cmd.coord_y;
            rad_q <= cmd.radius;
            idx <= '0;
            pend <= 1'b0;
            ret <= S_IDLE;
            case (cmd_e'(cmd.command)) inside
              CMD_ADD: state <= S_ADD;
              CMD_LIST, CMD_FIND_NAME, CMD_FIND_XY, CMD_DELETE, CMD_RADIUS: begin
                if (cnt == '0) begin
                  em <= mk(ST_NONE, '0, 1'b1);
                  state <= S_EMIT;
                end else if (cmd_e'(cmd.command) == CMD_RADIUS) begin
                  state <= S_RSQ;
                end else begin
                  state <= S_RD;
                end
              end
              default: begin
                em <= mk(ST_NONE, '0, 1'b1);
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_ADD: begin
          if (cnt == CW'(TABLE_DEPTH)) begin
            em <= mk(ST_FULL, '0, 1'b1);
          end else begin
            em <= mk(ST_OK, new_rec, 1'b1);
            cnt <= cnt + CW'(1);
          end
          ret <= S_IDLE;
          state <= S_EMIT;
        end
        S_RSQ: begin
          r2 <= prod[47:16];
          state <= S_RD;
        end
        S_RD: state <= S_EV;
        S_EV: begin
          case (cmd_q) inside
            CMD_LIST: begin
              em <= mk(ST_OK, rdata, lastidx);
              ret <= lastidx ? S_IDLE : S_NXT;
              state <= S_EMIT;
            end
            CMD_FIND_NAME, CMD_DELETE: begin
              if (rdata.name == key_q) begin
                em <= mk(ST_OK, rdata, 1'b1);
                ret <= (cmd_q == CMD_DELETE) ? S_SHF : S_IDLE;
                state <= S_EMIT;
              end else begin
                state <= S_NXT;
              end
            end
            CMD_FIND_XY: begin
              if (rdata.x == qx && rdata.y == qy) begin
                em <= mk(ST_OK, rdata, 1'b1);
                ret <= S_IDLE;
                state <= S_EMIT;
              end else begin
                state <= S_NXT;
              end
            end
            CMD_RADIUS: begin
              adx <= dx[16] ? 16'(-dx) : dx[15:0];
              ady <= dy[16] ? 16'(-dy) : dy[15:0];
              state <= S_MX;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_MX: begin
          acc <= prod[31:0];
          state <= S_MY;
        end
        S_MY: begin
          sum <= {1'b0, acc} + {1'b0, prod[31:0]};
          state <= S_CMP;
        end
        S_CMP: begin
          if (sum <= {1'b0, r2}) begin
            pend <= 1'b1;
            pend_rec <= rdata;
            if (pend) begin
              em <= mk(ST_OK, pend_rec, 1'b0);
              ret <= S_NXT;
              state <= S_EMIT;
            end else begin
              state <= S_NXT;
            end
          end else begin
            state <= S_NXT;
          end
        end
        S_NXT: begin
          if (lastidx) begin
            if (cmd_q == CMD_RADIUS && pend) begin
              em <= mk(ST_OK, pend_rec, 1'b1);
            end else begin
              em <= mk(ST_NONE, '0, 1'b1);
            end
            ret <= S_IDLE;
            state <= S_EMIT;
          end else begin
            idx <= idx + IW'(1);
            state <= S_RD;
          end
        end
        S_EMIT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp <= em;
            rsp_valid <= 1'b1;
            state <= ret;
          end
        end
        S_SHF: begin
          if (CW'(idx) + CW'(1) >= cnt) begin
            cnt <= cnt - CW'(1);
            state <= S_IDLE;
          end else begin
            idx <= idx + IW'(1);
            state <= S_SHR;
          end
        end
        S_SHR: state <= S_SHW;
        S_SHW: state <= S_SHF;
        default: state <= S_IDLE;
      endcase
    end
  end

  `PRTRQ_ASSERT_NEXT(a_busy_after_accept, cmd_valid && !cmd_stall, cmd_stall)
  `PRTRQ_ASSERT_IMPL(a_more_means_busy, rsp_valid && !rsp.last_item, cmd_stall)
  `PRTRQ_ASSERT_NEXT(a_full_holds_count, state == S_ADD && cnt == CW'(TABLE_DEPTH), $stable(cnt))
  `PRTRQ_ASSERT_IMPL(a_full_is_last, rsp_valid && rsp.status_code == ST_FULL, rsp.last_item)

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import prtrq_pkg::*;

  localparam int DEPTH = 16;
  localparam int STALL_LIMIT = 6000;

  class record_table_scoreboard;
    bit [63:0] nm0[DEPTH];
    bit [63:0] nm1[DEPTH];
    bit [31:0] nm2[DEPTH];
    logic signed [15:0] px[DEPTH];
    logic signed [15:0] py[DEPTH];
    int count;
    out_t expected_rsp[$];
    int mismatches;
    int checked;

    function out_t make_rsp(logic [1:0] status, int idx, bit last);
      out_t r;
      r = '0;
      r.status_code = status;
      if (idx >= 0) begin
        r.entry_name0 = nm0[idx];
        r.entry_name1 = nm1[idx];
        r.entry_name2 = nm2[idx];
        r.entry_x = px[idx];
        r.entry_y = py[idx];
      end
      r.last_item = last;
      return r;
    endfunction

    function void note_command(in_t c);
      int hits;
      int hit_idx;
      longint dx;
      longint dy;
      longint d2;
      longint rr;
      hits = 0;
      case (c.command)
        CMD_ADD: begin
          if (count >= DEPTH) begin
            expected_rsp.push_back(make_rsp(ST_FULL, -1, 1));
          end else begin
            nm0[count] = c.key_part0;
            nm1[count] = c.key_part1;
            nm2[count] = c.key_part2;
            px[count] = c.coord_x;
            py[count] = c.coord_y;
            expected_rsp.push_back(make_rsp(ST_OK, count, 1));
            count++;
          end
          hits = 1;
        end
        CMD_LIST: begin
          for (int i = 0; i < count; i++)
            expected_rsp.push_back(make_rsp(ST_OK, i, i == count - 1));
          hits = count;
        end
        CMD_FIND_NAME, CMD_DELETE: begin
          hit_idx = -1;
          for (int i = 0; i < count; i++)
            if (hit_idx < 0 && nm0[i] == c.key_part0 && nm1[i] == c.key_part1 &&
                nm2[i] == c.key_part2)
              hit_idx = i;
          if (hit_idx >= 0) begin
            expected_rsp.push_back(make_rsp(ST_OK, hit_idx, 1));
            hits = 1;
            if (c.command == CMD_DELETE) begin
              for (int i = hit_idx; i + 1 < count; i++) begin
                nm0[i] = nm0[i + 1];
                nm1[i] = nm1[i + 1];
                nm2[i] = nm2[i + 1];
                px[i] = px[i + 1];
                py[i] = py[i + 1];
              end
              count--;
            end
          end
        end
        CMD_FIND_XY: begin
          for (int i = 0; i < count; i++)
            if (hits == 0 && px[i] == c.coord_x && py[i] == c.coord_y) begin
              expected_rsp.push_back(make_rsp(ST_OK, i, 1));
              hits = 1;
            end
        end
        CMD_RADIUS: begin
          rr = longint'(c.radius) * longint'(c.radius);
          for (int i = 0; i < count; i++) begin
            dx = longint'(px[i]) - longint'(c.coord_x);
            dy = longint'(py[i]) - longint'(c.coord_y);
            d2 = dx * dx + dy * dy;
            if ((d2 << 16) <= rr) begin
              expected_rsp.push_back(make_rsp(ST_OK, i, 0));
              hits++;
            end
          end
          if (hits > 0) expected_rsp[$].last_item = 1'b1;
        end
        default: ;
      endcase
      if (hits == 0) expected_rsp.push_back(make_rsp(ST_NONE, -1, 1));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = expected_rsp.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cmd_valid = 0;
  logic cmd_stall;
  in_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 0;
  out_t rsp;

  record_table_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int cmds_sent = 0;
  bit [63:0] pool0[6];
  bit [63:0] pool1[6];
  bit [31:0] pool2[6];
  logic signed [15:0] pool_x[4];
  logic signed [15:0] pool_y[4];

  point_record_table_radius_query_top uut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(rsp);
    if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_cmd(in_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid = 0;
      @(negedge clk);
    end
    cmd = c;
    cmd_valid = 1;
    do @(posedge clk); while (cmd_stall);
    sb.note_command(c);
    cmds_sent++;
    @(negedge clk);
    cmd_valid = 0;
  endtask

  function automatic in_t build_cmd(logic [2:0] op, int name_sel, logic signed [15:0] x,
                                    logic signed [15:0] y, logic [23:0] rad);
    in_t c;
    c = '0;
    c.command = op;
    if (name_sel >= 0) begin
      c.key_part0 = pool0[name_sel];
      c.key_part1 = pool1[name_sel];
      c.key_part2 = pool2[name_sel];
    end else begin
      c.key_part0 = {$urandom, $urandom};
      c.key_part1 = {$urandom, $urandom};
      c.key_part2 = $urandom;
    end
    c.coord_x = x;
    c.coord_y = y;
    c.radius = rad;
    return c;
  endfunction

  function automatic in_t random_cmd();
    int r;
    int pick;
    logic [2:0] op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [23:0] rad;
    r = $urandom_range(99);
    if (r < 30) op = CMD_ADD;
    else if (r < 40) op = CMD_LIST;
    else if (r < 55) op = CMD_FIND_NAME;
    else if (r < 65) op = CMD_FIND_XY;
    else if (r < 82) op = CMD_DELETE;
    else if (r < 97) op = CMD_RADIUS;
    else op = 3'($urandom_range(6, 7));
    pick = $urandom_range(3);
    if ($urandom_range(9) < 7) begin
      x = pool_x[pick] + 16'($signed($urandom_range(0, 40)) - 20);
      y = pool_y[pick] + 16'($signed($urandom_range(0, 40)) - 20);
    end else begin
      x = 16'($urandom);
      y = 16'($urandom);
    end
    rad = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 12000));
    return build_cmd(op, ($urandom_range(9) < 8) ? $urandom_range(5) : -1, x, y, rad);
  endfunction

  task automatic drain();
    while (sb.expected_rsp.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    sb = new();
    for (int i = 0; i < 6; i++) begin
      pool0[i] = {$urandom, $urandom};
      pool1[i] = {$urandom, $urandom};
      pool2[i] = $urandom;
    end
    pool0[1] = 64'h0000_0000_0000_0041;
    pool1[1] = '0;
    pool2[1] = '0;
    pool0[2] = 64'h0000_0000_4200_0041;
    pool1[2] = '0;
    pool2[2] = '0;
    pool_x = '{16'sd0, -16'sd32768, 16'sd32767, 16'sd300};
    pool_y = '{16'sd0, 16'sd32767, -16'sd32768, -16'sd250};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_cmd(build_cmd(CMD_LIST, 0, 0, 0, 0));
    send_cmd(build_cmd(CMD_FIND_NAME, 0, 0, 0, 0));
    send_cmd(build_cmd(CMD_RADIUS, 0, 0, 0, 24'hFFFFFF));
    send_cmd(build_cmd(3'd6, 0, 0, 0, 0));
    send_cmd(build_cmd(3'd7, -1, -1, -1, 24'hFFFFFF));
    send_cmd(build_cmd(CMD_ADD, 1, -16'sd32768, 16'sd32767, 0));
    send_cmd(build_cmd(CMD_ADD, 2, 16'sd32767, -16'sd32768, 0));
    send_cmd(build_cmd(CMD_ADD, -1, 0, 0, 0));
    send_cmd(build_cmd(CMD_FIND_NAME, 2, 0, 0, 0));
    send_cmd(build_cmd(CMD_FIND_XY, 0, 16'sd32767, -16'sd32768, 0));
    send_cmd(build_cmd(CMD_FIND_XY, 0, 1, 1, 0));
    send_cmd(build_cmd(CMD_RADIUS, 0, 0, 0, 0));
    send_cmd(build_cmd(CMD_RADIUS, 0, 0, 0, 24'hFFFFFF));
    send_cmd(build_cmd(CMD_RADIUS, 0, 16'sd3, 16'sd4, 24'd1280));
    send_cmd(build_cmd(CMD_DELETE, 1, 0, 0, 0));
    send_cmd(build_cmd(CMD_DELETE, 1, 0, 0, 0));
    send_cmd(build_cmd(CMD_LIST, 0, 0, 0, 0));
    for (int i = 0; i < 15; i++)
      send_cmd(build_cmd(CMD_ADD, $urandom_range(5), 16'($urandom), 16'($urandom), 0));
    send_cmd(build_cmd(CMD_ADD, 3, 0, 0, 0));
    send_cmd(build_cmd(CMD_LIST, 0, 0, 0, 0));
    send_cmd(build_cmd(CMD_RADIUS, 0, 0, 0, 24'hFFFFFF));
    send_cmd(build_cmd(CMD_DELETE, 2, 0, 0, 0));
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 88; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 88; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (int n = 0; n < 111; n++) send_cmd(random_cmd());
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    $display("covered %0d commands and %0d result beats under four idle/stall mixes",
             cmds_sent, sb.checked);
    if (sb.mismatches == 0 && sb.expected_rsp.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.expected_rsp.size());
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
